@@ design/assert_macros.svh @@
// Assertion shorthands for the pairwise distance checker.
// Included by the checker file only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: label, clock, active-low reset, property, message.
`define PDM_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Form for checkers that see the block's clk and arst_n.
`define PDM_CHECK(lbl, prop, msg) `PDM_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

@@ design/pdm_pkg.sv @@
// Shared widths and constants of the pairwise distance matrix block.
// No dependencies; used by the top level, the checker and the bench.
package pdm_pkg;
	localparam int IDX_W  = 6;
	localparam int DIST_W = 25;
	localparam logic [DIST_W-1:0] DIST_MAX = 25'd33554431;
endpackage

@@ design/pdm_store.sv @@
// Point store: single write port, single registered read port.
// No dependencies.
module pdm_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ design/pdm_sqrt.sv @@
// Iterative integer square root, one root bit per cycle.
// No dependencies; instantiated by the top level.
module pdm_sqrt #(
	parameter int ROOT_W = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);
	localparam int RAD_W = 2 * ROOT_W;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;

	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] rem_nx;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_nx = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse after the last iteration
			done_q <= run_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= rem_nx[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

@@ design/pairwise_distance_matrix_top.sv @@
// Pairwise Euclidean distance block: top level, sequencer, difference and
// shared multiplier. Depends on pdm_pkg, pdm_store and pdm_sqrt.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------------
//  input     | start & !busy         | new_set, x_coord, y_coord
//  result    | result_valid (strobe) | earlier_index, new_index, distance,
//            |                       | overflow, last
//
// Timing: an item that is dropped (store full) or opens a set leaves busy low;
// its result, if any, shows the cycle after acceptance. An item with n earlier
// points keeps busy high while each of its n pairs passes through the read,
// difference, two squares, sum and bit-serial square root, one bit per cycle.
// Reset clears the point count and sequencer; the store holds garbage until
// written, and only written entries are read. The receiver cannot stall.
module pairwise_distance_matrix_top
	import pdm_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         new_set,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	output logic                         result_valid,
	output logic [IDX_W-1:0]             earlier_index,
	output logic [IDX_W-1:0]             new_index,
	output logic [DIST_W-1:0]            distance,
	output logic                         overflow,
	output logic                         last
);
	localparam int IW     = $clog2(MAX_POINTS);       // store address
	localparam int CW     = $clog2(MAX_POINTS + 1);   // point count
	localparam int PW     = 2 * COORD_BITS;           // stored point {x, y}
	localparam int SQ_W   = 2 * COORD_BITS;           // one square
	localparam int ROOT_W = COORD_BITS + 1;           // root of a sum of two squares
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int EXT_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;  // store read in flight
	localparam logic [2:0] ST_DIFF = 3'd2;  // absolute differences
	localparam logic [2:0] ST_SQX  = 3'd3;  // dx squared
	localparam logic [2:0] ST_SQY  = 3'd4;  // dy squared
	localparam logic [2:0] ST_ADD  = 3'd5;  // sum, launch root
	localparam logic [2:0] ST_ROOT = 3'd6;  // wait for root

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         j_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [COORD_BITS-1:0] dx_q, dy_q;
	logic [SQ_W-1:0]       prod_q, sq_q;

	logic                  result_valid_q;
	logic [IDX_W-1:0]      earlier_index_q, new_index_q;
	logic [DIST_W-1:0]     distance_q;
	logic                  overflow_q, last_q;

	// accept path
	logic          accept;
	logic [CW-1:0] base;
	logic          full;
	logic          we;

	assign accept = start && (state_q == ST_IDLE);
	assign base   = new_set ? '0 : count_q;
	assign full   = (base == CW'(MAX_POINTS));
	assign we     = accept && !full;

	logic [PW-1:0] rdata;

	pdm_store #(
		.DEPTH (MAX_POINTS),
		.WIDTH (PW),
		.AW    (IW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (base[IW-1:0]),
		.wdata ({x_coord, y_coord}),
		.raddr (j_q),
		.rdata (rdata)
	);

	// absolute coordinate differences, one sign bit wider than a coordinate
	logic [COORD_BITS-1:0] rx, ry;
	logic [COORD_BITS:0]   dxs, dys, adx, ady;

	always_comb begin
		rx  = rdata[PW-1:COORD_BITS];
		ry  = rdata[COORD_BITS-1:0];
		dxs = {x_q[COORD_BITS-1], x_q} - {rx[COORD_BITS-1], rx};
		dys = {y_q[COORD_BITS-1], y_q} - {ry[COORD_BITS-1], ry};
		adx = dxs[COORD_BITS] ? -dxs : dxs;
		ady = dys[COORD_BITS] ? -dys : dys;
	end

	// the one multiplier, shared by both squares
	logic [COORD_BITS-1:0] mul_op;
	logic [SQ_W-1:0]       mul_res;

	assign mul_op  = (state_q == ST_SQX) ? dx_q : dy_q;
	assign mul_res = SQ_W'(mul_op) * SQ_W'(mul_op);

	// square root
	logic              sq_start;
	logic [RAD_W-1:0]  radicand;
	logic              sq_done;
	logic [ROOT_W-1:0] root;

	assign sq_start = (state_q == ST_ADD);
	assign radicand = RAD_W'(sq_q) + RAD_W'(prod_q);

	pdm_sqrt #(
		.ROOT_W (ROOT_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (root)
	);

	// saturate wide roots to the distance field
	logic [EXT_W-1:0]  root_ext;
	logic [DIST_W-1:0] dist_sat;

	always_comb begin
		root_ext = EXT_W'(root);
		dist_sat = (root_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_ext);
	end

	logic pair_last;
	assign pair_last = ((j_q + IW'(1)) == idx_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// strobe for a dropped point or a finished pair
			result_valid_q <= (accept && full) || ((state_q == ST_ROOT) && sq_done);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !full) begin
						count_q <= base + CW'(1);
						if (base != '0) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sq_done) begin
						state_q <= pair_last ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= x_coord;
			y_q   <= y_coord;
			idx_q <= base[IW-1:0];
			j_q   <= '0;
			if (full) begin
				earlier_index_q <= '0;
				new_index_q     <= '0;
				distance_q      <= '0;
				overflow_q      <= 1'b1;
				last_q          <= 1'b1;
			end
		end
		if (state_q == ST_DIFF) begin
			dx_q <= adx[COORD_BITS-1:0];
			dy_q <= ady[COORD_BITS-1:0];
		end
		if (state_q == ST_SQX) begin
			prod_q <= mul_res;
		end
		if (state_q == ST_SQY) begin
			sq_q   <= prod_q;
			prod_q <= mul_res;
		end
		if (state_q == ST_ROOT && sq_done) begin
			earlier_index_q <= IDX_W'(j_q);
			new_index_q     <= IDX_W'(idx_q);
			distance_q      <= dist_sat;
			overflow_q      <= 1'b0;
			last_q          <= pair_last;
			j_q             <= j_q + IW'(1);
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_valid  = result_valid_q;
	assign earlier_index = earlier_index_q;
	assign new_index     = new_index_q;
	assign distance      = distance_q;
	assign overflow      = overflow_q;
	assign last          = last_q;
endmodule

@@ design/pdm_checker.sv @@
// Port-level checker for the pairwise distance block, bound to the top level.
// Depends on pdm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pdm_checker
	import pdm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              busy,
	input logic              result_valid,
	input logic [IDX_W-1:0]  earlier_index,
	input logic [IDX_W-1:0]  new_index,
	input logic [DIST_W-1:0] distance,
	input logic              overflow,
	input logic              last
);
	logic ovf_shape;

	assign ovf_shape = last && distance == '0 && earlier_index == '0 && new_index == '0;

	// a dropped point gives one all-zero final item
	`PDM_CHECK(a_ovf_item, result_valid && overflow |-> ovf_shape, "overflow item malformed")

	// busy falls together with the final item of a walk
	`PDM_CHECK(a_last_idle, result_valid && !overflow |-> (busy == !last), "busy disagrees with last")

	// no item shows right as a walk begins
	`PDM_CHECK(a_rise_quiet, $rose(busy) |-> !result_valid, "item at walk start")

	// items within a walk are spaced by the root iterations
	`PDM_CHECK(a_spacing, result_valid && !last |=> !result_valid, "back-to-back items in a walk")
endmodule

bind pairwise_distance_matrix_top pdm_checker u_pdm_checker (.*);

@@ verif/pairwise_distance_matrix_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pairwise_distance_matrix_top: a scoreboard class predicts
// every pair distance and overflow item, and plain tasks drive 2D points. Depends on pdm_pkg.
module pairwise_distance_matrix_top_tb;
	import pdm_pkg::*;

	localparam int CW        = 24;       // coordinate width, matches the block default
	localparam int MAX_PTS   = 64;       // store depth, matches the block default
	localparam int RAND_PTS  = 350;      // rough number of random points
	localparam int STALL_MAX = 5000;     // cycles with no handshake before giving up
	localparam int DRAIN_CYC = 100;      // quiet cycles at the end to catch stray results

	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

	// One expected result item: the pair indices, their floored distance and the overflow and last flags.
	typedef struct packed {
		logic [IDX_W-1:0]  earlier_index;
		logic [IDX_W-1:0]  new_index;
		logic [DIST_W-1:0] distance;
		logic              overflow;
		logic              last;
	} pair_result_t;

	// Keeps its own copy of the point set and the results still owed by the block.
	class distance_board;
		logic signed [CW-1:0] set_x [MAX_PTS];
		logic signed [CW-1:0] set_y [MAX_PTS];
		int                   set_size = 0;
		pair_result_t         owed_pairs [$];
		int                   bad_count = 0;

		// Digit-by-digit square root, two bits of the radicand per step.
		function automatic logic [DIST_W-1:0] floor_root(logic [63:0] radicand);
			logic [63:0] rem;
			logic [63:0] root;
			logic [63:0] trial;
			rem  = '0;
			root = '0;
			for (int i = 31; i >= 0; i--) begin
				rem   = (rem << 2) | ((radicand >> (2 * i)) & 64'd3);
				trial = (root << 2) | 64'd1;
				if (rem >= trial) begin
					rem  = rem - trial;
					root = (root << 1) | 64'd1;
				end else begin
					root = root << 1;
				end
			end
			if (root > 64'(DIST_MAX))
				return DIST_MAX;
			return root[DIST_W-1:0];
		endfunction

		function void flag(string what);
			bad_count++;
			if (bad_count <= 10)
				$display("%0t: mismatch: %s", $realtime, what);
		endfunction

		// Accepted point: queue one result per earlier point, or one overflow item.
		function void note_point(logic fresh, logic signed [CW-1:0] px,
				logic signed [CW-1:0] py);
			pair_result_t r;
			longint       dx;
			longint       dy;
			if (fresh)
				set_size = 0;
			if (set_size >= MAX_PTS) begin
				r = '{earlier_index: '0, new_index: '0, distance: '0,
					overflow: 1'b1, last: 1'b1};
				owed_pairs.insert(owed_pairs.size(), r);
				return;
			end
			for (int j = 0; j < set_size; j++) begin
				dx = longint'(set_x[j]) - longint'(px);
				dy = longint'(set_y[j]) - longint'(py);
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				r.earlier_index = IDX_W'(j);
				r.new_index     = IDX_W'(set_size);
				r.distance      = floor_root(64'(dx * dx) + 64'(dy * dy));
				r.overflow      = 1'b0;
				r.last          = (j + 1 == set_size);
				owed_pairs.insert(owed_pairs.size(), r);
			end
			set_x[set_size] = px;
			set_y[set_size] = py;
			set_size++;
		endfunction

		// Result strobe seen: compare against the oldest owed result.
		function void check_result(pair_result_t got);
			pair_result_t want;
			if (owed_pairs.size() == 0) begin
				flag($sformatf("unexpected result ei=%0d ni=%0d dist=%0d ovf=%0b last=%0b",
					got.earlier_index, got.new_index, got.distance, got.overflow, got.last));
				return;
			end
			want = owed_pairs.pop_front();
			if (got.earlier_index !== want.earlier_index || got.new_index !== want.new_index
					|| got.distance !== want.distance || got.overflow !== want.overflow
					|| got.last !== want.last)
				flag($sformatf({"expected ei=%0d ni=%0d dist=%0d ovf=%0b last=%0b, ",
					"got ei=%0d ni=%0d dist=%0d ovf=%0b last=%0b"},
					want.earlier_index, want.new_index, want.distance, want.overflow,
					want.last, got.earlier_index, got.new_index, got.distance,
					got.overflow, got.last));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 new_set;
	logic signed [CW-1:0] x_coord;
	logic signed [CW-1:0] y_coord;
	logic                 result_valid;
	logic [IDX_W-1:0]     earlier_index;
	logic [IDX_W-1:0]     new_index;
	logic [DIST_W-1:0]    distance;
	logic                 overflow;
	logic                 last;

	distance_board board = new;
	int            points_sent = 0;
	int            quiet_cycles = 0;
	bit            calm = 0;        // when set, the sender never idles

	pairwise_distance_matrix_top #(
		.MAX_POINTS (MAX_PTS),
		.COORD_BITS (CW)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.new_set       (new_set),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.result_valid  (result_valid),
		.earlier_index (earlier_index),
		.new_index     (new_index),
		.distance      (distance),
		.overflow      (overflow),
		.last          (last)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Monitor: inputs were set at the falling edge, outputs are read here before
	// the block updates them. Points are noted before results are checked; the
	// result of a point never shows on the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_point(new_set, x_coord, y_coord);
			if (result_valid)
				board.check_result('{earlier_index: earlier_index, new_index: new_index,
					distance: distance, overflow: overflow, last: last});

			// Watchdog: any handshake, in or out, counts as progress.
			if ((start && !busy) || result_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_MAX) begin
				$display("%0t: no progress for %0d cycles", $realtime, STALL_MAX);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Coordinates: mostly full-range random, with the extremes and small values
	// mixed in so equal and near-equal points show up.
	function automatic logic signed [CW-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return C_MIN;
			1:       return C_MAX;
			2, 3:    return CW'($signed($urandom_range(0, 511)) - 256);
			default: return CW'($urandom);
		endcase
	endfunction

	// Idle for a random number of cycles (scrambling the fields meanwhile), then
	// present the point and hold it until the block takes it. start stays high
	// after acceptance; an idle gap in the next call or wait_empty lowers it.
	task automatic send_point(logic fresh, logic signed [CW-1:0] px,
			logic signed [CW-1:0] py);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			start   <= 1'b0;
			new_set <= 1'($urandom);
			x_coord <= CW'($urandom);
			y_coord <= CW'($urandom);
		end
		@(negedge clk);
		start   <= 1'b1;
		new_set <= fresh;
		x_coord <= px;
		y_coord <= py;
		do @(posedge clk); while (busy);
		points_sent++;
	endtask

	// Hold off the sender until every owed result has come back.
	task automatic wait_empty();
		@(negedge clk);
		start <= 1'b0;
		while (board.owed_pairs.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int   set_len;
		logic fresh;

		arst_n  = 1'b0;
		start   = 1'b0;
		new_set = 1'b0;
		x_coord = '0;
		y_coord = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: first point after reset without new_set, coincident points,
		// opposite corners (largest distance), axis spans, back-to-back restarts.
		send_point(1'b0, '0, '0);
		send_point(1'b0, '0, '0);
		send_point(1'b0, C_MIN, C_MIN);
		send_point(1'b0, C_MAX, C_MAX);
		send_point(1'b0, C_MAX, C_MIN);
		send_point(1'b0, C_MIN, C_MAX);
		send_point(1'b0, CW'(256), -CW'(256));
		send_point(1'b1, C_MAX, '0);
		send_point(1'b0, C_MIN, '0);
		send_point(1'b0, '0, C_MIN);
		send_point(1'b1, -CW'(1), -CW'(1));
		send_point(1'b1, CW'(5), CW'(5));
		send_point(1'b0, CW'(24'h555555), CW'(24'hAAAAAA));
		send_point(1'b0, CW'(24'hAAAAAA), CW'(24'h555555));
		send_point(1'b0, CW'(1), CW'(0));
		wait_empty();

		// Random sets: mostly short, now and then a full store followed by a few
		// points that must overflow. The first set opens fresh, long enough to fill
		// the store. A few sets continue the last one; a stray restart can hit mid-set.
		for (int s = 0; points_sent < RAND_PTS + 15; s++) begin
			if (s == 0 || $urandom_range(0, 9) == 0)
				set_len = MAX_PTS + $urandom_range(1, 3);
			else
				set_len = $urandom_range(1, 16);
			calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < set_len; k++) begin
				if (k == 0)
					fresh = ($urandom_range(0, 7) != 0);
				else
					fresh = ($urandom_range(0, 39) == 0);
				if (s == 0 && k == 0)
					fresh = 1'b1;
				send_point(fresh, pick_coord(), pick_coord());
			end
			if ($urandom_range(0, 3) == 0)
				wait_empty();
		end

		// Wind down: stop sending, let the last results arrive, then watch a while
		// for anything extra.
		wait_empty();
		repeat (DRAIN_CYC) @(posedge clk);
		if (board.owed_pairs.size() != 0)
			board.flag($sformatf("%0d results never arrived", board.owed_pairs.size()));

		if (board.bad_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
